// File: rtl/core/hlt_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table package
// Shared codes, payload types and helper functions of the liveness table.
// ----------------------------------------------------------------------------
`default_nettype none

package hlt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CNT_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST  = 24'd3000;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 24'd1000;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_MIN  = 24'd500;
  localparam logic [CNT_W-1:0]      CNT_MAX      = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_BEAT  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_BEAT,
    OP_TICK,
    OP_QUERY
  } op_e;

  typedef enum logic [3:0] {
    EV_INVALID   = 4'd0,
    EV_FULL      = 4'd1,
    EV_NEW       = 4'd2,
    EV_RECONNECT = 4'd3,
    EV_STILL     = 4'd4,
    EV_OFFLINE   = 4'd5,
    EV_SWEEP     = 4'd6,
    EV_IDLE      = 4'd7,
    EV_FOUND     = 4'd8,
    EV_NOT_FOUND = 4'd9
  } ev_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TCHK,
    ST_SCAN,
    ST_EMIT
  } st_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] id;
    logic [7:0] dev;
    logic [7:0] veh;
  } item_t;

  typedef struct packed {
    ev_e              kind;
    logic [7:0]       id;
    logic [7:0]       dev;
    logic [7:0]       veh;
    logic             online;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] ticks;
    logic [5:0]       online_count;
    logic [CNT_W-1:0] beats;
    logic [CNT_W-1:0] online_events;
    logic [CNT_W-1:0] timeouts;
    logic             last;
  } out_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic out_t no_slot(input ev_e kind, input logic [7:0] id);
    out_t r;
    r      = '0;
    r.kind = kind;
    r.id   = id;
    r.last = 1'b1;
    no_slot = r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hlt_if.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table channels
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hlt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] system_id;
  logic [7:0] device_type;
  logic [7:0] vehicle_type;
  modport source (output valid, cmd, system_id, device_type, vehicle_type, input ready);
  modport sink (input valid, cmd, system_id, device_type, vehicle_type, output ready);
endinterface

interface hlt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [7:0]  node_id;
  logic [7:0]  node_device_type;
  logic [7:0]  node_vehicle_type;
  logic        node_online;
  logic [31:0] node_beat_count;
  logic [31:0] ticks_since_beat;
  logic [5:0]  online_count;
  logic [31:0] total_beats;
  logic [31:0] total_online_events;
  logic [31:0] total_timeouts;
  logic        last;
  modport source (output valid, event_kind, node_id, node_device_type, node_vehicle_type,
                  node_online, node_beat_count, ticks_since_beat, online_count, total_beats,
                  total_online_events, total_timeouts, last, input ready);
  modport sink (input valid, event_kind, node_id, node_device_type, node_vehicle_type,
                node_online, node_beat_count, ticks_since_beat, online_count, total_beats,
                total_online_events, total_timeouts, last, output ready);
endinterface

interface hlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/heartbeat_liveness_table_core.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table
// Tracks remote nodes by system id, reports liveness and sweeps for timeouts.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_i    | in        | cmd, system_id, device_type, vehicle_type
//  out_o   | out       | one result item, last marks the final one of an item
//  cfg_i   | in        | index 0 timeout_ticks, index 1 check_interval_ticks
//
// Heartbeats and queries read the table through one memory port, one slot per
// cycle while no result is being emitted. An idle tick emits one item; a
// sweeping tick emits one item per offline node and a final sweep item.
// Reset empties the table at once; there is no clearing pass.
// A stalled output holds the engine; the queue keeps taking up to two items.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_liveness_table_core #(
  parameter int NODE_SLOTS = 32,
  parameter int TIME_BITS  = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hlt_in_if.sink    in_i,
  hlt_out_if.source out_o,
  hlt_cfg_if.sink   cfg_i
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  hlt_pkg::item_t push_item, pop_item;

  hlt_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  hlt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  hlt_back #(
    .NODE_SLOTS (NODE_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .cfg_i        (cfg_i),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/hlt_front.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table front end
// Accepts input items, decodes the command and queues the valid ones.
// ----------------------------------------------------------------------------
`default_nettype none

module hlt_front (
  hlt_in_if.sink         in_i,
  output logic           push_valid_o,
  output hlt_pkg::item_t push_item_o,
  input  logic           push_ready_i
);

  always_comb begin
    push_item_o.id  = in_i.system_id;
    push_item_o.dev = in_i.device_type;
    push_item_o.veh = in_i.vehicle_type;
    push_valid_o    = in_i.valid;
    case (in_i.cmd)
      hlt_pkg::CMD_BEAT:  push_item_o.op = hlt_pkg::OP_BEAT;
      hlt_pkg::CMD_TICK:  push_item_o.op = hlt_pkg::OP_TICK;
      hlt_pkg::CMD_QUERY: push_item_o.op = hlt_pkg::OP_QUERY;
      default: begin
        // An unused command is taken and dropped.
        push_item_o.op = hlt_pkg::OP_TICK;
        push_valid_o   = 1'b0;
      end
    endcase
  end

  assign in_i.ready = push_ready_i;

endmodule

`default_nettype wire

// File: rtl/core/hlt_fifo.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table queue
// Short queue between the front end and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hlt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hlt_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output hlt_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);

  localparam int PW = $clog2(hlt_pkg::QUEUE_DEPTH);
  localparam int FW = $clog2(hlt_pkg::QUEUE_DEPTH + 1);

  hlt_pkg::item_t mem_q [hlt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           push, pop;

  assign push_ready_o = (fill_q != FW'(hlt_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d   = push ? ((wr_q == PW'(hlt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d   = pop ? ((rd_q == PW'(hlt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    fill_d = fill_q + FW'(push) - FW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/hlt_back.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table engine
// Holds the node table, scans it one slot per cycle while no result is being emitted, and emits result items.
// ----------------------------------------------------------------------------
`default_nettype none

module hlt_back #(
  parameter int NODE_SLOTS = 32,
  parameter int TIME_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  hlt_pkg::item_t item_i,
  output logic           item_ready_o,
  hlt_cfg_if.sink        cfg_i,
  hlt_out_if.source      out_o
);

  localparam int IW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam int EW = (TIME_BITS > 24) ? TIME_BITS : 24;
  localparam logic [IW-1:0] LAST_IDX = IW'(NODE_SLOTS - 1);

  hlt_pkg::st_e   st_q, st_d;
  hlt_pkg::op_e   mode_q, mode_d;
  logic [7:0]     key_q, key_d, dev_q, dev_d, veh_q, veh_d;
  logic [TIME_BITS-1:0] time_q, time_d, sweep_q, sweep_d;
  logic [23:0]    timeout_q, timeout_d, interval_q, interval_d;
  logic [NODE_SLOTS-1:0] used_q, used_d, online_q, online_d;
  logic [IW-1:0]  idx_q, idx_d, chk_q, chk_d, free_q, free_d;
  logic           pend_q, pend_d, issued_q, issued_d, free_ok_q, free_ok_d;
  logic [CW-1:0]  ocnt_q, ocnt_d;
  logic [31:0]    beats_q, beats_d, onev_q, onev_d, tmo_q, tmo_d;
  hlt_pkg::out_t  resp_q, resp_d, out_q, out_d;
  logic           cont_q, cont_d, ovalid_q, ovalid_d;

  logic [7:0]           mem_id  [NODE_SLOTS];
  logic [7:0]           mem_dev [NODE_SLOTS];
  logic [7:0]           mem_veh [NODE_SLOTS];
  logic [TIME_BITS-1:0] mem_lb  [NODE_SLOTS];
  logic [31:0]          mem_cnt [NODE_SLOTS];
  logic [7:0]           rd_id_q, rd_dev_q, rd_veh_q;
  logic [TIME_BITS-1:0] rd_lb_q;
  logic [31:0]          rd_cnt_q;

  logic                 wr_en, wr_veh;
  logic [IW-1:0]        wr_addr;
  logic [31:0]          wr_cnt;
  logic [TIME_BITS-1:0] elapsed;
  logic [31:0]          ticks;
  logic                 hit, act, out_free;

  assign cfg_i.ready = 1'b1;
  assign elapsed = time_q - rd_lb_q;
  assign ticks = (elapsed > TIME_BITS'(hlt_pkg::CNT_MAX)) ? hlt_pkg::CNT_MAX : 32'(elapsed);
  assign hit = used_q[chk_q] && (rd_id_q == key_q);
  assign out_free = !ovalid_q || out_o.ready;
  assign item_ready_o = (st_q == hlt_pkg::ST_IDLE);

  always_comb begin
    timeout_d  = timeout_q;
    interval_d = interval_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        hlt_pkg::CFG_TIMEOUT:
          timeout_d = (cfg_i.data < hlt_pkg::TIMEOUT_MIN) ? hlt_pkg::TIMEOUT_MIN : cfg_i.data;
        hlt_pkg::CFG_INTERVAL: interval_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;       mode_d = mode_q;     key_d = key_q;
    dev_d = dev_q;     veh_d = veh_q;       time_d = time_q;
    sweep_d = sweep_q; used_d = used_q;     online_d = online_q;
    idx_d = idx_q;     chk_d = chk_q;       free_d = free_q;
    pend_d = pend_q;   issued_d = issued_q; free_ok_d = free_ok_q;
    ocnt_d = ocnt_q;   beats_d = beats_q;   onev_d = onev_q;
    tmo_d = tmo_q;     resp_d = resp_q;     cont_d = cont_q;
    out_d = out_q;     ovalid_d = ovalid_q && !out_o.ready;
    wr_en = 1'b0;      wr_veh = 1'b0;       wr_addr = chk_q;
    wr_cnt = hlt_pkg::sat_inc(rd_cnt_q);
    act = 1'b0;
    case (st_q)
      hlt_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          mode_d = item_i.op;
          key_d = item_i.id;
          dev_d = item_i.dev;
          veh_d = item_i.veh;
          idx_d = '0;
          pend_d = 1'b0;
          issued_d = 1'b0;
          free_ok_d = 1'b0;
          cont_d = 1'b0;
          case (item_i.op)
            hlt_pkg::OP_BEAT: begin
              if (item_i.id == 8'd0) begin
                resp_d = hlt_pkg::no_slot(hlt_pkg::EV_INVALID, 8'd0);
                st_d = hlt_pkg::ST_EMIT;
              end else begin
                beats_d = hlt_pkg::sat_inc(beats_q);
                st_d = hlt_pkg::ST_SCAN;
              end
            end
            hlt_pkg::OP_TICK: begin
              time_d = time_q + 1'b1;
              st_d = hlt_pkg::ST_TCHK;
            end
            hlt_pkg::OP_QUERY: begin
              if (item_i.id == 8'd0) begin
                resp_d = hlt_pkg::no_slot(hlt_pkg::EV_NOT_FOUND, 8'd0);
                st_d = hlt_pkg::ST_EMIT;
              end else begin
                st_d = hlt_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      hlt_pkg::ST_TCHK: begin
        if (EW'(time_q - sweep_q) >= EW'(interval_q)) begin
          st_d = hlt_pkg::ST_SCAN;
        end else begin
          resp_d = hlt_pkg::no_slot(hlt_pkg::EV_IDLE, 8'd0);
          st_d = hlt_pkg::ST_EMIT;
        end
      end
      hlt_pkg::ST_SCAN: begin
        if (pend_q) begin
          resp_d = '0;
          resp_d.id = rd_id_q;
          resp_d.dev = rd_dev_q;
          resp_d.veh = rd_veh_q;
          resp_d.count = rd_cnt_q;
          resp_d.last = 1'b1;
          case (mode_q)
            hlt_pkg::OP_BEAT: begin
              if (hit) begin
                act = 1'b1;
                wr_en = 1'b1;
                online_d[chk_q] = 1'b1;
                if (!online_q[chk_q]) begin
                  onev_d = hlt_pkg::sat_inc(onev_q);
                  ocnt_d = ocnt_q + 1'b1;
                end
                resp_d.kind = online_q[chk_q] ? hlt_pkg::EV_STILL : hlt_pkg::EV_RECONNECT;
                resp_d.dev = dev_q;
                resp_d.online = 1'b1;
                resp_d.count = wr_cnt;
              end else if (!used_q[chk_q] && !free_ok_q) begin
                free_ok_d = 1'b1;
                free_d = chk_q;
              end
            end
            hlt_pkg::OP_QUERY: begin
              if (hit) begin
                act = 1'b1;
                resp_d.kind = hlt_pkg::EV_FOUND;
                resp_d.online = online_q[chk_q];
                resp_d.ticks = ticks;
              end
            end
            default: begin
              if (used_q[chk_q] && online_q[chk_q] && (EW'(elapsed) > EW'(timeout_q))) begin
                act = 1'b1;
                online_d[chk_q] = 1'b0;
                tmo_d = hlt_pkg::sat_inc(tmo_q);
                ocnt_d = ocnt_q - 1'b1;
                resp_d.kind = hlt_pkg::EV_OFFLINE;
                resp_d.ticks = ticks;
                resp_d.last = 1'b0;
                cont_d = 1'b1;
              end
            end
          endcase
        end
        if (act) begin
          pend_d = 1'b0;
          idx_d = chk_q + 1'b1;
          st_d = hlt_pkg::ST_EMIT;
        end else if (!issued_q) begin
          pend_d = 1'b1;
          chk_d = idx_q;
          idx_d = idx_q + 1'b1;
          issued_d = (idx_q == LAST_IDX);
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          cont_d = 1'b0;
          st_d = hlt_pkg::ST_EMIT;
          case (mode_q)
            hlt_pkg::OP_BEAT: begin
              if (free_ok_q) begin
                wr_en = 1'b1;
                wr_veh = 1'b1;
                wr_addr = free_q;
                wr_cnt = 32'd1;
                used_d[free_q] = 1'b1;
                online_d[free_q] = 1'b1;
                onev_d = hlt_pkg::sat_inc(onev_q);
                ocnt_d = ocnt_q + 1'b1;
                resp_d = hlt_pkg::no_slot(hlt_pkg::EV_NEW, key_q);
                resp_d.dev = dev_q;
                resp_d.veh = veh_q;
                resp_d.online = 1'b1;
                resp_d.count = 32'd1;
              end else begin
                resp_d = hlt_pkg::no_slot(hlt_pkg::EV_FULL, key_q);
              end
            end
            hlt_pkg::OP_QUERY: resp_d = hlt_pkg::no_slot(hlt_pkg::EV_NOT_FOUND, key_q);
            default: begin
              sweep_d = time_q;
              resp_d = hlt_pkg::no_slot(hlt_pkg::EV_SWEEP, 8'd0);
            end
          endcase
        end
      end
      hlt_pkg::ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          out_d = resp_q;
          out_d.online_count = 6'(ocnt_q);
          out_d.beats = beats_q;
          out_d.online_events = onev_q;
          out_d.timeouts = tmo_q;
          st_d = cont_q ? hlt_pkg::ST_SCAN : hlt_pkg::ST_IDLE;
        end
      end
      default: st_d = hlt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hlt_pkg::ST_IDLE;
      mode_q <= hlt_pkg::OP_TICK;
      time_q <= '0;
      sweep_q <= '0;
      timeout_q <= hlt_pkg::TIMEOUT_RST;
      interval_q <= hlt_pkg::INTERVAL_RST;
      used_q <= '0;
      online_q <= '0;
      idx_q <= '0;
      chk_q <= '0;
      pend_q <= 1'b0;
      issued_q <= 1'b0;
      free_ok_q <= 1'b0;
      ocnt_q <= '0;
      beats_q <= '0;
      onev_q <= '0;
      tmo_q <= '0;
      cont_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mode_q <= mode_d;
      time_q <= time_d;
      sweep_q <= sweep_d;
      timeout_q <= timeout_d;
      interval_q <= interval_d;
      used_q <= used_d;
      online_q <= online_d;
      idx_q <= idx_d;
      chk_q <= chk_d;
      pend_q <= pend_d;
      issued_q <= issued_d;
      free_ok_q <= free_ok_d;
      ocnt_q <= ocnt_d;
      beats_q <= beats_d;
      onev_q <= onev_d;
      tmo_q <= tmo_d;
      cont_q <= cont_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    dev_q <= dev_d;
    veh_q <= veh_d;
    free_q <= free_d;
    resp_q <= resp_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_id[wr_addr] <= key_q;
      mem_dev[wr_addr] <= dev_q;
      mem_lb[wr_addr] <= time_q;
      mem_cnt[wr_addr] <= wr_cnt;
    end
    if (wr_veh) begin
      mem_veh[wr_addr] <= veh_q;
    end
    rd_id_q <= mem_id[idx_q];
    rd_dev_q <= mem_dev[idx_q];
    rd_veh_q <= mem_veh[idx_q];
    rd_lb_q <= mem_lb[idx_q];
    rd_cnt_q <= mem_cnt[idx_q];
  end

  assign out_o.valid = ovalid_q;
  assign out_o.event_kind = out_q.kind;
  assign out_o.node_id = out_q.id;
  assign out_o.node_device_type = out_q.dev;
  assign out_o.node_vehicle_type = out_q.veh;
  assign out_o.node_online = out_q.online;
  assign out_o.node_beat_count = out_q.count;
  assign out_o.ticks_since_beat = out_q.ticks;
  assign out_o.online_count = out_q.online_count;
  assign out_o.total_beats = out_q.beats;
  assign out_o.total_online_events = out_q.online_events;
  assign out_o.total_timeouts = out_q.timeouts;
  assign out_o.last = out_q.last;

endmodule

`default_nettype wire

// File: rtl/core/hlt_checker.sv
// ----------------------------------------------------------------------------
// Heartbeat liveness table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hlt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] event_kind_i,
  input logic       node_online_i,
  input logic [31:0] ticks_i,
  input logic [5:0] online_count_i,
  input logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_offline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == hlt_pkg::EV_OFFLINE) |-> !node_online_i && !last_i)
    else $error("offline result malformed");

  a_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == hlt_pkg::EV_NEW || event_kind_i == hlt_pkg::EV_RECONNECT ||
    event_kind_i == hlt_pkg::EV_STILL) |-> node_online_i && (ticks_i == 32'd0) && last_i)
    else $error("heartbeat result malformed");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_kind_i <= hlt_pkg::EV_NOT_FOUND)
    else $error("unknown event kind");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == hlt_pkg::EV_NEW) |-> online_count_i != 6'd0)
    else $error("online count missed a new node");

endmodule

bind heartbeat_liveness_table_core hlt_checker u_hlt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .event_kind_i   (out_o.event_kind),
  .node_online_i  (out_o.node_online),
  .ticks_i        (out_o.ticks_since_beat),
  .online_count_i (out_o.online_count),
  .last_i         (out_o.last)
);

`default_nettype wire
